>>> hw/rtl/hcbp_pkg.sv
// Shared types and constants for the Huffman code bit packer.
`default_nettype none

package hcbp_pkg;

   localparam int ALPHABET_SIZE = 256;
   localparam int MAX_CODE_LEN  = 32;

   localparam int SYM_W   = 8;
   localparam int CODE_W  = 32;
   localparam int LEN_W   = 6;
   localparam int BYTE_W  = 8;
   localparam int FILL_W  = 3;
   localparam int MAX_OUT = 4;
   localparam int CNT_W   = 3;

   localparam int IDX_W   = $clog2(ALPHABET_SIZE);
   localparam int TABLE_W = CODE_W + LEN_W;
   localparam int COMB_W  = BYTE_W + CODE_W;

   localparam logic [SYM_W:0]   SYM_LIMIT   = (SYM_W + 1)'(ALPHABET_SIZE);
   localparam logic [LEN_W-1:0] MAX_LEN_VAL = LEN_W'(MAX_CODE_LEN);
   localparam logic [CNT_W-1:0] MAX_OUT_VAL = CNT_W'(MAX_OUT);

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_ENCODE = 2'd1,
      OP_FLUSH  = 2'd2
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [SYM_W-1:0]  symbol;
      logic [CODE_W-1:0] code_value;
      logic [LEN_W-1:0]  code_length;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              last;
   } rsp_type;

endpackage

`default_nettype wire

>>> hw/rtl/hcbp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module hcbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/huffman_code_bit_packer.sv
// Top level of the table-driven Huffman encoder with MSB-first byte packer.
//
// Input channel req_*: one item per handshake. op load writes a code word and
// length into the code table, op encode appends the symbol's code bits to the
// byte accumulator, op flush emits the partial byte zero-padded and clears it.
// Result channel rsp_*: one packed byte per handshake, last marks the final
// byte caused by an input item. Loads and codeless symbols give no bytes.
// The code table read data is registered; the bytes of an encode or flush then
// pass the lookup stage and the output buffer register before they reach rsp.
// Throughput: one item per cycle while rsp_ready is high and each item yields at
// most one byte; an item yielding more (at most four) holds the pipeline until
// the four-byte buffer, draining a byte per ready cycle, is down to its last byte.
// A load followed at once by an encode of the same symbol reads the new entry.
// Reset clears the code length valid bits (all symbols have no code), the
// accumulator, and the pipeline; the code word memory is not cleared.
// When the receiver stalls, the output buffer holds its bytes and the stage
// behind it, then req_ready, drops once a new item would need the buffer.
`default_nettype none

module huffman_code_bit_packer
   import hcbp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output      logic    req_ready,
   input  wire req_type req_data,
   output      logic    rsp_valid,
   input  wire logic    rsp_ready,
   output      rsp_type rsp_data
);

   // request side
   logic               req_accept;
   logic               sym_in_range;
   logic [LEN_W-1:0]   load_len;
   logic               tbl_we;
   logic               tbl_re;
   logic [TABLE_W-1:0] tbl_rdata;

   logic [ALPHABET_SIZE-1:0] code_valid_ff, code_valid_in;

   // lookup stage
   logic   s1_valid_ff, s1_valid_in;
   op_type s1_op_ff;
   logic   s1_hit_ff;
   logic   s1_go;

   // accumulator
   logic [BYTE_W-1:0] acc_ff, acc_in;
   logic [FILL_W-1:0] fill_ff, fill_in;

   // output buffer
   logic [MAX_OUT-1:0][BYTE_W-1:0] obuf_ff, obuf_in;
   logic [CNT_W-1:0]               ocnt_ff, ocnt_in;
   logic                           out_busy;
   logic                           rsp_pop;

   // datapath
   logic [CODE_W-1:0] rd_word;
   logic [LEN_W-1:0]  rd_len;
   logic [LEN_W-1:0]  enc_n;
   logic [CODE_W-1:0] aligned;
   logic [COMB_W-1:0] comb;
   logic [COMB_W-1:0] comb_rest;
   logic [LEN_W-1:0]  total;
   logic [CNT_W-1:0]  nbytes;

   assign req_accept   = req_valid && req_ready;
   assign sym_in_range = {1'b0, req_data.symbol} < SYM_LIMIT;
   assign load_len     = (req_data.code_length > MAX_LEN_VAL) ? MAX_LEN_VAL
                                                              : req_data.code_length;
   assign tbl_we = req_accept && (req_data.op == OP_LOAD) && sym_in_range;
   assign tbl_re = req_accept && (req_data.op == OP_ENCODE);

   hcbp_ram #(
      .WIDTH (TABLE_W),
      .DEPTH (ALPHABET_SIZE)
   ) u_code_table (
      .clock (clock),
      .we    (tbl_we),
      .waddr (req_data.symbol[IDX_W-1:0]),
      .wdata ({req_data.code_value, load_len}),
      .re    (tbl_re),
      .raddr (req_data.symbol[IDX_W-1:0]),
      .rdata (tbl_rdata)
   );

   assign rd_word = tbl_rdata[TABLE_W-1 -: CODE_W];
   assign rd_len  = tbl_rdata[LEN_W-1:0];

   assign rsp_valid         = (ocnt_ff != '0);
   assign rsp_pop           = rsp_valid && rsp_ready;
   assign rsp_data.out_byte = obuf_ff[0];
   assign rsp_data.last     = (ocnt_ff == CNT_W'(1));

   // the buffer is free for new bytes once its last byte leaves this cycle
   assign out_busy  = (ocnt_ff > CNT_W'(1)) || ((ocnt_ff == CNT_W'(1)) && !rsp_ready);
   assign s1_go     = s1_valid_ff && !out_busy;
   assign req_ready = !s1_valid_ff || s1_go;

   // merge code bits after the held bits; a codeless symbol shifts in nothing
   assign enc_n     = s1_hit_ff ? rd_len : '0;
   assign aligned   = rd_word << (LEN_W'(CODE_W) - enc_n);
   assign comb      = {acc_ff, CODE_W'(0)} | ({aligned, BYTE_W'(0)} >> fill_ff);
   assign total     = {(LEN_W - FILL_W)'(0), fill_ff} + enc_n;
   assign nbytes    = total[LEN_W-1:FILL_W];
   assign comb_rest = comb << {nbytes, FILL_W'(0)};

   always_comb begin
      code_valid_in = code_valid_ff;
      if (tbl_we) begin
         code_valid_in[req_data.symbol[IDX_W-1:0]] = 1'b1;
      end

      s1_valid_in = s1_valid_ff;
      if (req_ready) begin
         s1_valid_in = req_accept &&
                       ((req_data.op == OP_ENCODE) || (req_data.op == OP_FLUSH));
      end

      acc_in  = acc_ff;
      fill_in = fill_ff;
      obuf_in = obuf_ff;
      ocnt_in = ocnt_ff;

      if (rsp_pop) begin
         for (int i = 0; i < MAX_OUT - 1; i++) begin
            obuf_in[i] = obuf_ff[i + 1];
         end
         ocnt_in = ocnt_ff - CNT_W'(1);
      end

      if (s1_go) begin
         unique case (s1_op_ff)
            OP_ENCODE: begin
               for (int i = 0; i < MAX_OUT; i++) begin
                  obuf_in[i] = comb[COMB_W - 1 - BYTE_W * i -: BYTE_W];
               end
               ocnt_in = nbytes;
               acc_in  = comb_rest[COMB_W-1 -: BYTE_W];
               fill_in = total[FILL_W-1:0];
            end
            OP_FLUSH: begin
               obuf_in[0] = acc_ff;
               ocnt_in    = (fill_ff != '0) ? CNT_W'(1) : '0;
               acc_in     = '0;
               fill_in    = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_valid_ff <= '0;
         s1_valid_ff   <= 1'b0;
         acc_ff        <= '0;
         fill_ff       <= '0;
         ocnt_ff       <= '0;
      end else begin
         code_valid_ff <= code_valid_in;
         s1_valid_ff   <= s1_valid_in;
         acc_ff        <= acc_in;
         fill_ff       <= fill_in;
         ocnt_ff       <= ocnt_in;
      end
   end

   always_ff @(posedge clock) begin
      obuf_ff <= obuf_in;
      if (req_accept) begin
         s1_op_ff  <= req_data.op;
         s1_hit_ff <= sym_in_range && code_valid_ff[req_data.symbol[IDX_W-1:0]];
      end
   end

   // checks

   a_ocnt_bound: assert property (@(posedge clock) disable iff (reset)
      ocnt_ff <= MAX_OUT_VAL)
      else $error("output buffer count above its depth");

   a_acc_clean: assert property (@(posedge clock) disable iff (reset)
      (acc_ff & (8'hFF >> fill_ff)) == '0)
      else $error("accumulator holds bits past its fill count");

   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      (s1_go && (s1_op_ff == OP_FLUSH)) |=> (fill_ff == '0) && (acc_ff == '0))
      else $error("flush left bits in the accumulator");

   a_stall_holds_lookup: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_go) |=> $stable(tbl_rdata) && s1_valid_ff)
      else $error("table read data lost while lookup stage stalled");

endmodule

`default_nettype wire
